// ===== design/owm_pkg.sv =====
// Shared types and constants for the 1-Wire bus master.
`default_nettype none

package owm_pkg;

    // Command codes carried in a request
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Bus reset outcome codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_PRESENCE = 2'd1,
        ST_STUCK_LOW   = 2'd2
    } t_status;

    // Operation phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_RST_LOW  = 6'b000010,
        PH_RST_PRES = 6'b000100,
        PH_RST_REC  = 6'b001000,
        PH_WRITE    = 6'b010000,
        PH_READ     = 6'b100000
    } t_phase;

    // Microsecond timing, in the width of the microsecond counter
    localparam int US_W = 9;
    localparam logic [US_W-1:0] PRESENCE_US  = 9'd65;
    localparam logic [US_W-1:0] RECOVER_US   = 9'd415;
    localparam logic [US_W-1:0] WR_LOW_US    = 9'd10;
    localparam logic [US_W-1:0] RD_LOW_US    = 9'd1;
    localparam logic [US_W-1:0] RD_SAMPLE_US = 9'd15;
    localparam logic [US_W-1:0] SLOT_US      = 9'd60;
    localparam logic [3:0]      BYTE_SLOTS   = 4'd8;

    // One input request
    typedef struct packed {
        logic       line_level;
        logic [7:0] write_data;
        t_cmd       command;
    } t_item;

    // One result, ordered so that the last field sits in the lowest bits
    typedef struct packed {
        logic [7:0] read_data;
        logic       rejected;
        logic [1:0] status;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } t_result;

endpackage

`default_nettype wire

// ===== design/one_wire_master.sv =====
// Top level of the 1-Wire bus master: stream ports, input and result registers.
//
//  Channel   Dir  Handshake                     Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   command, write_data, line_level
//  m_axis    out  m_axis_tvalid/m_axis_tready   drive_low .. read_data
//  cfg       in   i_cfg_we                      ticks_per_us
//
// Each request is one bus clock tick and yields one result. A request is
// registered in the input register, applied to the timing state machine and
// lands in the result register; one request can be taken every cycle while
// the result is not stalled. A stalled result holds both registers; nothing is lost.
// Reset is synchronous and active low; ticks_per_us returns to 16.
`default_nettype none

module one_wire_master #(
    parameter int RESET_LOW_US = 480
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] command, [9:2] write_data, [10] line_level, [15:11] zero
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status, [5] rejected,
    // [13:6] read_data, [15:14] zero
    output logic [15:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);
    import owm_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result step_result;
    logic [7:0] r_ticks_per_us;
    logic    out_free;
    logic    advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_result};

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_us <= 8'd16;
        end else if (i_cfg_we) begin
            r_ticks_per_us <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= t_item'(s_axis_tdata[10:0]);
        end
    end

    owm_step #(
        .RESET_LOW_US (RESET_LOW_US)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_item         (r_item),
        .i_ticks_per_us (r_ticks_per_us),
        .o_result       (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

endmodule

`default_nettype wire

// ===== design/owm_step.sv =====
// Timing state machine: applies one clock tick request to the bus master state.
`default_nettype none

module owm_step #(
    parameter int RESET_LOW_US = 480
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire owm_pkg::t_item   i_item,
    input  wire logic [7:0]       i_ticks_per_us,
    output owm_pkg::t_result      o_result
);
    import owm_pkg::*;

    localparam logic [US_W-1:0] RstLowUs = US_W'(RESET_LOW_US);

    t_phase          r_phase,    n_phase;
    logic [US_W-1:0] r_us,       n_us;
    logic [7:0]      r_pre,      n_pre;
    logic [3:0]      r_slot,     n_slot;
    logic [7:0]      r_shift,    n_shift;
    logic            r_presence, n_presence;
    logic [1:0]      r_status,   n_status;
    logic [7:0]      r_read,     n_read;

    logic            done;
    logic            rej;
    logic            us_tick;
    logic [8:0]      pre_inc;
    logic [US_W-1:0] us_inc;
    logic [3:0]      slot_inc;
    logic            drive;

    // Next state for one tick
    always_comb begin
        n_phase    = r_phase;
        n_us       = r_us;
        n_pre      = r_pre;
        n_slot     = r_slot;
        n_shift    = r_shift;
        n_presence = r_presence;
        n_status   = r_status;
        n_read     = r_read;
        done       = 1'b0;
        rej        = 1'b0;
        pre_inc    = {1'b0, r_pre} + 9'd1;
        us_tick    = (pre_inc >= {1'b0, i_ticks_per_us});
        us_inc     = r_us + US_W'(1);
        slot_inc   = r_slot + 4'd1;

        if (r_phase == PH_IDLE) begin
            // Start a new operation
            if (i_item.command != CMD_TICK) begin
                n_us   = '0;
                n_pre  = '0;
                n_slot = '0;
                unique case (i_item.command)
                    CMD_RESET: begin
                        n_phase = PH_RST_LOW;
                    end
                    CMD_WRITE: begin
                        n_phase = PH_WRITE;
                        n_shift = i_item.write_data;
                    end
                    default: begin
                        n_phase = PH_READ;
                        n_shift = '0;
                    end
                endcase
            end
        end else begin
            rej = (i_item.command != CMD_TICK);
            // Prescaler: one microsecond every ticks_per_us ticks, a setting of zero acting as one
            if (us_tick) begin
                n_pre = '0;
                n_us  = us_inc;
            end else begin
                n_pre = pre_inc[7:0];
            end
            if (us_tick) begin
                unique case (r_phase)
                    PH_RST_LOW: begin
                        if (us_inc >= RstLowUs) begin
                            n_phase = PH_RST_PRES;
                            n_us    = '0;
                        end
                    end
                    PH_RST_PRES: begin
                        if (us_inc >= PRESENCE_US) begin
                            n_presence = i_item.line_level;
                            n_phase    = PH_RST_REC;
                            n_us       = '0;
                        end
                    end
                    PH_RST_REC: begin
                        if (us_inc >= RECOVER_US) begin
                            if (!i_item.line_level) begin
                                n_status = ST_STUCK_LOW;
                            end else if (r_presence) begin
                                n_status = ST_NO_PRESENCE;
                            end else begin
                                n_status = ST_OK;
                            end
                            n_phase = PH_IDLE;
                            n_us    = '0;
                            done    = 1'b1;
                        end
                    end
                    PH_WRITE: begin
                        if (us_inc >= SLOT_US) begin
                            n_shift = {1'b0, r_shift[7:1]};
                            n_slot  = slot_inc;
                            n_us    = '0;
                            if (slot_inc >= BYTE_SLOTS) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        end
                    end
                    PH_READ: begin
                        if (us_inc == RD_SAMPLE_US) begin
                            n_shift = {i_item.line_level, r_shift[7:1]};
                        end
                        if (us_inc >= SLOT_US) begin
                            n_slot = slot_inc;
                            n_us   = '0;
                            if (slot_inc >= BYTE_SLOTS) begin
                                n_read  = n_shift;
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Bus drive from the state after the tick
    always_comb begin
        case (n_phase)
            PH_RST_LOW: drive = 1'b1;
            PH_WRITE:   drive = (n_us < WR_LOW_US) || !n_shift[0];
            PH_READ:    drive = (n_us < RD_LOW_US);
            default:    drive = 1'b0;
        endcase
    end

    assign o_result.drive_low = drive;
    assign o_result.busy_res  = (n_phase != PH_IDLE);
    assign o_result.done_res  = done;
    assign o_result.status    = n_status;
    assign o_result.rejected  = rej;
    assign o_result.read_data = n_read;

    // State registers, updated once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_us       <= '0;
            r_pre      <= '0;
            r_slot     <= '0;
            r_shift    <= '0;
            r_presence <= 1'b0;
            r_status   <= ST_OK;
            r_read     <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_us       <= n_us;
            r_pre      <= n_pre;
            r_slot     <= n_slot;
            r_shift    <= n_shift;
            r_presence <= n_presence;
            r_status   <= n_status;
            r_read     <= n_read;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_one_wire_master.sv =====
// Self-checking testbench for the 1-Wire bus master: streamed ticks in, checked bus outputs out.
`timescale 1ns / 1ps

module tb_one_wire_master;
    import owm_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_LOW_US    = 480;
    // Window after the reset-low phase in which a device holds its presence pulse.
    localparam int PRESENCE_WIN_US = 120;

    // Line level shapes used while a bus operation runs.
    typedef enum logic [2:0] {
        LN_RAND,
        LN_HIGH,
        LN_LOW,
        LN_PRESENT,
        LN_LATE_LOW
    } t_line;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = '0;

    // Pending ticks for the driver and bus outputs still to be seen.
    t_item   tick_q[$];
    t_result bus_out_q[$];

    // Shadow of the master's state and its prescaler setting.
    t_phase     bus_phase    = PH_IDLE;
    logic [8:0] bus_us       = '0;
    logic [7:0] bus_pre      = '0;
    logic [3:0] bus_slot     = '0;
    logic [7:0] bus_shift    = '0;
    logic       bus_presence = 1'b0;
    t_status    bus_status   = ST_OK;
    logic [7:0] bus_rd_hold  = '0;
    logic [7:0] bus_tpu      = 8'd16;

    // Stimulus bookkeeping.
    logic [7:0] fill_rate    = 8'd16;
    logic       quiet_tail   = 1'b0;
    longint     queued_ticks = 0;
    longint     cycle_count  = 0;
    int         op_count     = 0;
    int         src_gap      = 0;
    int         sink_gap     = 0;

    // Results and coverage tallies.
    int      err_count    = 0;
    int      results_seen = 0;
    int      resets_ok    = 0;
    int      resets_nop   = 0;
    int      resets_stuck = 0;
    int      writes_done  = 0;
    int      reads_done   = 0;
    int      rejects_seen = 0;
    t_result got_res;
    t_result want_res;

    one_wire_master #(
        .RESET_LOW_US(RESET_LOW_US)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advance the shadow master by one tick and return the bus outputs it should show.
    function automatic t_result master_step(t_item it);
        t_result r;
        logic    us_tick;
        r = '0;
        if (bus_phase == PH_IDLE) begin
            if (it.command != CMD_TICK) begin
                bus_us   = '0;
                bus_pre  = '0;
                bus_slot = '0;
                case (it.command)
                    CMD_RESET: bus_phase = PH_RST_LOW;
                    CMD_WRITE: begin
                        bus_phase = PH_WRITE;
                        bus_shift = it.write_data;
                    end
                    default: begin
                        bus_phase = PH_READ;
                        bus_shift = '0;
                    end
                endcase
            end
        end else begin
            if (it.command != CMD_TICK) begin
                r.rejected = 1'b1;
                rejects_seen++;
            end
            // A prescaler setting of zero behaves like one tick per microsecond.
            if (int'(bus_pre) + 1 >= int'(bus_tpu)) begin
                bus_pre = '0;
                bus_us  = bus_us + 9'd1;
                us_tick = 1'b1;
            end else begin
                bus_pre = bus_pre + 8'd1;
                us_tick = 1'b0;
            end
            if (us_tick) begin
                case (bus_phase)
                    PH_RST_LOW: begin
                        if (bus_us >= RESET_LOW_US) begin
                            bus_phase = PH_RST_PRES;
                            bus_us    = '0;
                        end
                    end
                    PH_RST_PRES: begin
                        if (bus_us >= PRESENCE_US) begin
                            bus_presence = it.line_level;
                            bus_phase    = PH_RST_REC;
                            bus_us       = '0;
                        end
                    end
                    PH_RST_REC: begin
                        if (bus_us >= RECOVER_US) begin
                            // A line still low at the end outranks a missing presence pulse.
                            if (!it.line_level) begin
                                bus_status = ST_STUCK_LOW;
                                resets_stuck++;
                            end else if (bus_presence) begin
                                bus_status = ST_NO_PRESENCE;
                                resets_nop++;
                            end else begin
                                bus_status = ST_OK;
                                resets_ok++;
                            end
                            bus_phase  = PH_IDLE;
                            bus_us     = '0;
                            r.done_res = 1'b1;
                        end
                    end
                    PH_WRITE: begin
                        if (bus_us >= SLOT_US) begin
                            bus_shift = bus_shift >> 1;
                            bus_slot  = bus_slot + 4'd1;
                            bus_us    = '0;
                            if (bus_slot >= BYTE_SLOTS) begin
                                bus_phase  = PH_IDLE;
                                r.done_res = 1'b1;
                                writes_done++;
                            end
                        end
                    end
                    PH_READ: begin
                        if (bus_us == RD_SAMPLE_US) begin
                            bus_shift = {it.line_level, bus_shift[7:1]};
                        end
                        if (bus_us >= SLOT_US) begin
                            bus_slot = bus_slot + 4'd1;
                            bus_us   = '0;
                            if (bus_slot >= BYTE_SLOTS) begin
                                bus_rd_hold = bus_shift;
                                bus_phase   = PH_IDLE;
                                r.done_res  = 1'b1;
                                reads_done++;
                            end
                        end
                    end
                    default: bus_phase = PH_IDLE;
                endcase
            end
        end
        case (bus_phase)
            PH_RST_LOW: r.drive_low = 1'b1;
            PH_WRITE:   r.drive_low = (bus_us < WR_LOW_US) || !bus_shift[0];
            PH_READ:    r.drive_low = (bus_us < RD_LOW_US);
            default:    r.drive_low = 1'b0;
        endcase
        r.busy_res  = (bus_phase != PH_IDLE);
        r.status    = bus_status;
        r.read_data = bus_rd_hold;
        return r;
    endfunction

    // Bus level seen by the master at tick k of an operation.
    function automatic logic line_at(t_line mode, int k, int per_us);
        case (mode)
            LN_HIGH:     return 1'b1;
            LN_LOW:      return 1'b0;
            LN_PRESENT:  return !(k > RESET_LOW_US * per_us &&
                                  k <= (RESET_LOW_US + PRESENCE_WIN_US) * per_us);
            LN_LATE_LOW: return !(k > (RESET_LOW_US + PRESENCE_WIN_US) * per_us);
            default:     return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
        err_count++;
        if (err_count <= 40) begin
            $display("[%0t] result %0d: %s got %h expected %h",
                     $realtime, results_seen, what, got_v, want_v);
        end
    endtask

    // Queue a command and its ticks, with optional busy commands. A cut from one
    // up to the full span queues only that many ticks from the start; otherwise every tick until done.
    task automatic queue_op(t_cmd cmd, logic [7:0] wd, t_line mode, int noise,
                            bit hit_done, int cut);
        int    per_us;
        int    span;
        int    k;
        int    k_end;
        t_item it;
        per_us = (fill_rate == 0) ? 1 : int'(fill_rate);
        if (cmd == CMD_RESET) begin
            span = (RESET_LOW_US + int'(PRESENCE_US) + int'(RECOVER_US)) * per_us;
        end else begin
            span = int'(BYTE_SLOTS) * int'(SLOT_US) * per_us;
        end
        k_end = (cut > 0 && cut <= span) ? cut - 1 : span;
        for (k = 0; k <= k_end; k++) begin
            it.command    = CMD_TICK;
            it.write_data = 8'($urandom);
            it.line_level = line_at(mode, k, per_us);
            if (k == 0) begin
                it.command    = cmd;
                it.write_data = wd;
            end else if ((k == span && hit_done) ||
                         (noise > 0 && $urandom_range(1, span) <= noise)) begin
                it.command = t_cmd'($urandom_range(1, 3));
            end
            tick_q.push_back(it);
        end
        queued_ticks += k_end + 1;
        op_count++;
    endtask

    task automatic queue_idle(int n);
        t_item it;
        repeat (n) begin
            it.command    = CMD_TICK;
            it.write_data = 8'($urandom);
            it.line_level = 1'($urandom_range(0, 1));
            tick_q.push_back(it);
        end
        queued_ticks += n;
    endtask

    // Wait until every queued tick is in and its result checked, then change the prescaler.
    task automatic set_rate(logic [7:0] v);
        do @(negedge i_clk);
        while (tick_q.size() != 0 || s_axis_tvalid || bus_out_q.size() != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        bus_tpu   = v;
        fill_rate = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Request driver: takes ticks from the queue, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                bus_out_q.push_back(master_step(t_item'(s_axis_tdata[10:0])));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 3);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tdata  <= {5'b0, tick_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Result monitor: checks each accepted result and stalls the output at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (bus_out_q.size() == 0) begin
                    flag_mismatch("unexpected result", m_axis_tdata, '0);
                end else begin
                    want_res = bus_out_q.pop_front();
                    got_res  = t_result'(m_axis_tdata[13:0]);
                    if (got_res.drive_low !== want_res.drive_low)
                        flag_mismatch("drive_low", 16'(got_res.drive_low),
                                      16'(want_res.drive_low));
                    if (got_res.busy_res !== want_res.busy_res)
                        flag_mismatch("busy_res", 16'(got_res.busy_res),
                                      16'(want_res.busy_res));
                    if (got_res.done_res !== want_res.done_res)
                        flag_mismatch("done_res", 16'(got_res.done_res),
                                      16'(want_res.done_res));
                    if (got_res.status !== want_res.status)
                        flag_mismatch("status", 16'(got_res.status), 16'(want_res.status));
                    if (got_res.rejected !== want_res.rejected)
                        flag_mismatch("rejected", 16'(got_res.rejected),
                                      16'(want_res.rejected));
                    if (got_res.read_data !== want_res.read_data)
                        flag_mismatch("read_data", 16'(got_res.read_data),
                                      16'(want_res.read_data));
                    if (m_axis_tdata[15:14] !== 2'b00)
                        flag_mismatch("pad bits", 16'(m_axis_tdata[15:14]), '0);
                end
                results_seen++;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog scaled to the number of ticks queued so far.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 40 * queued_ticks + 100000) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, bus_out_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus: idle ticks, a whole read byte, then the start of the opening slot of a write.
    initial begin
        // Default prescaler: idle ticks only.
        queue_idle(6);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A zero setting acts like one: a whole read byte with commands arriving
        // while busy, one of them on the completing tick.
        set_rate(8'd0);
        queue_op(CMD_READ, 8'h00, LN_RAND, 3, 1'b1, 0);
        queue_idle(6);

        // Last part without idling: the start of the first slot of a write at one tick per microsecond.
        set_rate(8'd1);
        quiet_tail <= 1'b1;
        queue_op(CMD_WRITE, 8'($urandom), LN_RAND, 1, 1'b0, 24);

        do @(negedge i_clk);
        while (tick_q.size() != 0 || s_axis_tvalid || bus_out_q.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results, %0d operations: read byte at prescaler 0, write slot at 1.",
                 results_seen, op_count);
        $display("Resets %0d/%0d/%0d (ok/absent/stuck), writes %0d, reads %0d, rejects %0d.",
                 resets_ok, resets_nop, resets_stuck, writes_done, reads_done, rejects_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/owm_pkg.sv
design/owm_step.sv
design/one_wire_master.sv
tb/tb_one_wire_master.sv
